// File: rtl/cpc_pkg.sv
// ----------------------------------------------------------------------------
// cpc_pkg
// Shared widths, microcode word layout and the microcode program of the
// Chebyshev coefficient generator.
// ----------------------------------------------------------------------------
package cpc_pkg;

	localparam int POW_W         = 6;
	localparam int COEF_W        = 41;
	localparam int DEF_MAX_ORDER = 32;
	localparam int ROW_W         = 2;
	localparam int STEP_W        = 4;

	typedef logic [STEP_W-1:0] step_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_INIT0,
		OP_INIT1,
		OP_INIT2,
		OP_CALC,
		OP_NEXTK,
		OP_EMIT_SET,
		OP_EMIT_RD,
		OP_EMIT_WR,
		OP_EMIT_NXT
	} op_t;

	typedef enum logic [2:0] {
		JC_NONE,
		JC_ALWAYS,
		JC_NO_START,
		JC_SHORT,
		JC_P_LT_K,
		JC_K_LT_N,
		JC_OUT_BUSY,
		JC_P_NZ
	} jc_t;

	typedef struct packed {
		op_t   op;
		jc_t   jc;
		step_t target;
		logic  accept;
	} ctrl_t;

	typedef struct packed {
		logic start;
		logic short_n;
		logic p_lt_k;
		logic k_lt_n;
		logic out_busy;
		logic p_nz;
	} status_t;

	localparam step_t S_IDLE     = step_t'(0);
	localparam step_t S_INIT0    = step_t'(1);
	localparam step_t S_INIT1    = step_t'(2);
	localparam step_t S_INIT2    = step_t'(3);
	localparam step_t S_CALC     = step_t'(4);
	localparam step_t S_NEXTK    = step_t'(5);
	localparam step_t S_EMIT_SET = step_t'(6);
	localparam step_t S_EMIT_RD  = step_t'(7);
	localparam step_t S_EMIT_WR  = step_t'(8);
	localparam step_t S_EMIT_NXT = step_t'(9);
	localparam step_t S_DONE     = step_t'(10);

	function automatic ctrl_t ucode(input step_t step);
		ctrl_t w;
		w = '{op: OP_NONE, jc: JC_ALWAYS, target: S_IDLE, accept: 1'b0};
		unique case (step)
			S_IDLE:     w = '{op: OP_ACCEPT,   jc: JC_NO_START, target: S_IDLE,     accept: 1'b1};
			S_INIT0:    w = '{op: OP_INIT0,    jc: JC_NONE,     target: S_IDLE,     accept: 1'b0};
			S_INIT1:    w = '{op: OP_INIT1,    jc: JC_NONE,     target: S_IDLE,     accept: 1'b0};
			S_INIT2:    w = '{op: OP_INIT2,    jc: JC_SHORT,    target: S_EMIT_SET, accept: 1'b0};
			S_CALC:     w = '{op: OP_CALC,     jc: JC_P_LT_K,   target: S_CALC,     accept: 1'b0};
			S_NEXTK:    w = '{op: OP_NEXTK,    jc: JC_K_LT_N,   target: S_CALC,     accept: 1'b0};
			S_EMIT_SET: w = '{op: OP_EMIT_SET, jc: JC_NONE,     target: S_IDLE,     accept: 1'b0};
			S_EMIT_RD:  w = '{op: OP_EMIT_RD,  jc: JC_NONE,     target: S_IDLE,     accept: 1'b0};
			S_EMIT_WR:  w = '{op: OP_EMIT_WR,  jc: JC_OUT_BUSY, target: S_EMIT_WR,  accept: 1'b0};
			S_EMIT_NXT: w = '{op: OP_EMIT_NXT, jc: JC_P_NZ,     target: S_EMIT_RD,  accept: 1'b0};
			S_DONE:     w = '{op: OP_NONE,     jc: JC_ALWAYS,   target: S_IDLE,     accept: 1'b0};
			default:    w = '{op: OP_NONE,     jc: JC_ALWAYS,   target: S_IDLE,     accept: 1'b0};
		endcase
		return w;
	endfunction

endpackage

// File: rtl/cpc_seq.sv
// ----------------------------------------------------------------------------
// cpc_seq
// Step counter and microcode ROM: one control word per step, with
// conditional jumps on datapath status.
// ----------------------------------------------------------------------------
module cpc_seq
	import cpc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  status_t status,
	output ctrl_t   ctrl
);

	step_t step_q;
	logic  taken;

	assign ctrl = ucode(step_q);

	always_comb begin
		unique case (ctrl.jc)
			JC_NONE:     taken = 1'b0;
			JC_ALWAYS:   taken = 1'b1;
			JC_NO_START: taken = !status.start;
			JC_SHORT:    taken = status.short_n;
			JC_P_LT_K:   taken = status.p_lt_k;
			JC_K_LT_N:   taken = status.k_lt_n;
			JC_OUT_BUSY: taken = status.out_busy;
			JC_P_NZ:     taken = status.p_nz;
			default:     taken = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_IDLE;
		end else if (taken) begin
			step_q <= ctrl.target;
		end else begin
			step_q <= step_q + step_t'(1);
		end
	end

endmodule

// File: rtl/cpc_dp.sv
// ----------------------------------------------------------------------------
// cpc_dp
// Datapath: row memory (three rows of coefficients), shared shift and
// subtract unit, order and power counters, and the output register.
// ----------------------------------------------------------------------------
module cpc_dp
	import cpc_pkg::*;
#(
	parameter int MAX_ORDER = DEF_MAX_ORDER
)
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  ctrl_t                    ctrl,
	output status_t                  status,
	input  logic                     in_valid,
	input  logic [POW_W-1:0]         order,
	input  logic                     out_ready,
	output logic                     out_valid,
	output logic signed [COEF_W-1:0] coefficient,
	output logic [POW_W-1:0]         power,
	output logic                     last
);

	localparam int ADDR_W    = ROW_W + POW_W;
	localparam int MEM_DEPTH = 3 << POW_W;

	logic signed [COEF_W-1:0] mem [MEM_DEPTH];

	logic [POW_W-1:0] n_q, k_q, p_q;
	logic [ROW_W-1:0] older_q, prev_q, cur_q, out_row_q;

	logic [ADDR_W-1:0] rd_a_addr, rd_b_addr, wr_addr;
	logic              rd_a_en, rd_b_en, wr_en;
	logic signed [COEF_W-1:0] rd_a_q, rd_b_q, wr_data;

	logic                 calc_vld_s1;
	logic [POW_W-1:0]     p_s1;
	logic [ROW_W-1:0]     row_s1;
	logic                 use_prev_s1, use_older_s1;

	logic             out_valid_q;
	logic             out_busy;
	logic             load_out;
	logic [POW_W-1:0] n_sat;

	assign out_busy = out_valid_q && !out_ready;
	assign load_out = (ctrl.op == OP_EMIT_WR) && !out_busy;
	assign n_sat    = (order > POW_W'(MAX_ORDER)) ? POW_W'(MAX_ORDER) : order;

	assign status.start    = in_valid;
	assign status.short_n  = (n_q < POW_W'(2));
	assign status.p_lt_k   = (p_q != k_q);
	assign status.k_lt_n   = (k_q != n_q);
	assign status.out_busy = out_busy;
	assign status.p_nz     = (p_q != '0);

	// read ports: T(k-1)[p-1] and T(k-2)[p] while building, result row when emitting
	always_comb begin
		rd_a_en   = (ctrl.op == OP_CALC) || (ctrl.op == OP_EMIT_RD);
		rd_b_en   = (ctrl.op == OP_CALC);
		rd_a_addr = (ctrl.op == OP_CALC) ? {prev_q, p_q - POW_W'(1)} : {out_row_q, p_q};
		rd_b_addr = {older_q, p_q};
	end

	// write port: seed rows T0 and T1, then 2*T(k-1)[p-1] - T(k-2)[p]
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = {row_s1, p_s1};
		wr_data = (use_prev_s1 ? (rd_a_q <<< 1) : '0) - (use_older_s1 ? rd_b_q : '0);
		case (ctrl.op)
			OP_INIT0: begin
				wr_en   = 1'b1;
				wr_addr = {ROW_W'(0), POW_W'(0)};
				wr_data = COEF_W'(1);
			end
			OP_INIT1: begin
				wr_en   = 1'b1;
				wr_addr = {ROW_W'(1), POW_W'(0)};
				wr_data = '0;
			end
			OP_INIT2: begin
				wr_en   = 1'b1;
				wr_addr = {ROW_W'(1), POW_W'(1)};
				wr_data = COEF_W'(1);
			end
			default: begin
				wr_en = calc_vld_s1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_a_en) begin
			rd_a_q <= mem[rd_a_addr];
		end
		if (rd_b_en) begin
			rd_b_q <= mem[rd_b_addr];
		end
	end

	always_ff @(posedge clk) begin
		p_s1         <= p_q;
		row_s1       <= cur_q;
		use_prev_s1  <= (p_q != '0);
		use_older_s1 <= (({1'b0, p_q} + (POW_W+1)'(2)) <= {1'b0, k_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calc_vld_s1 <= 1'b0;
		end else begin
			calc_vld_s1 <= (ctrl.op == OP_CALC);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q       <= '0;
			k_q       <= '0;
			p_q       <= '0;
			older_q   <= ROW_W'(0);
			prev_q    <= ROW_W'(1);
			cur_q     <= ROW_W'(2);
			out_row_q <= ROW_W'(0);
		end else begin
			case (ctrl.op)
				OP_ACCEPT: begin
					if (in_valid) begin
						n_q     <= n_sat;
						k_q     <= POW_W'(2);
						p_q     <= '0;
						older_q <= ROW_W'(0);
						prev_q  <= ROW_W'(1);
						cur_q   <= ROW_W'(2);
					end
				end
				OP_CALC: begin
					p_q <= p_q + POW_W'(1);
				end
				OP_NEXTK: begin
					// rotate row roles instead of copying
					if (k_q != n_q) begin
						k_q     <= k_q + POW_W'(1);
						p_q     <= '0;
						older_q <= prev_q;
						prev_q  <= cur_q;
						cur_q   <= older_q;
					end
				end
				OP_EMIT_SET: begin
					p_q <= n_q;
					if (n_q == '0) begin
						out_row_q <= ROW_W'(0);
					end else if (n_q == POW_W'(1)) begin
						out_row_q <= ROW_W'(1);
					end else begin
						out_row_q <= cur_q;
					end
				end
				OP_EMIT_NXT: begin
					if (p_q != '0) begin
						p_q <= p_q - POW_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			coefficient <= rd_a_q;
			power       <= p_q;
			last        <= (p_q == '0);
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: rtl/chebyshev_poly_coeffs.sv
// ----------------------------------------------------------------------------
// chebyshev_poly_coeffs
// Coefficients of the Chebyshev polynomial of the first kind T_n.
//
// Input channel (in_valid/in_ready, order) takes one order n; orders above
// MAX_ORDER saturate to MAX_ORDER. Output channel (out_valid/out_ready)
// returns n+1 words, highest power first; last marks the constant term.
// A microcoded sequencer drives one shared shift-and-subtract unit over a
// three-row coefficient memory, T_k = 2x*T(k-1) - T(k-2), one coefficient
// per cycle, building a row for each k from 2 to n.
// Emission then reads each word through the memory read port.
// in_ready is high only while the sequencer waits at its idle step; the
// next order can be taken while the final word still sits in the output
// register. A stalled receiver holds the sequencer at its emit step.
// Reset clears the sequencer and the output valid; the row memory needs
// no clearing since every request rebuilds the rows it reads.
// ----------------------------------------------------------------------------
module chebyshev_poly_coeffs
	import cpc_pkg::*;
#(
	parameter int MAX_ORDER = DEF_MAX_ORDER
)
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [POW_W-1:0]         order,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [COEF_W-1:0] coefficient,
	output logic [POW_W-1:0]         power,
	output logic                     last
);

	ctrl_t   ctrl;
	status_t status;

	assign in_ready = ctrl.accept;

	cpc_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	cpc_dp #(
		.MAX_ORDER (MAX_ORDER)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.status      (status),
		.in_valid    (in_valid),
		.order       (order),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.coefficient (coefficient),
		.power       (power),
		.last        (last)
	);

endmodule
